@@ rtl/core/svct_pkg.sv @@
// Shared types, register map and codes for the shape volume containment test.
package svct_pkg;

  localparam int MAX_VERTICES_DEF = 64;

  localparam int CRD_W = 24;
  localparam int EXT_W = 23;
  localparam int CNT_W = 7;

  // Opcodes carried in the input tuser field.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Shape mode register codes.
  localparam logic [1:0] MODE_BOX    = 2'd0;
  localparam logic [1:0] MODE_SPHERE = 2'd1;
  localparam logic [1:0] MODE_PRISM  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_SHAPE_MODE    = 3'd0;
  localparam logic [2:0] REG_BOX_HALF_X    = 3'd1;
  localparam logic [2:0] REG_BOX_HALF_Y    = 3'd2;
  localparam logic [2:0] REG_BOX_HALF_Z    = 3'd3;
  localparam logic [2:0] REG_SPHERE_RADIUS = 3'd4;
  localparam logic [2:0] REG_PRISM_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_VERTEX_COUNT  = 3'd6;

  // Register reset values.
  localparam logic [1:0]       RST_SHAPE_MODE   = MODE_BOX;
  localparam logic [EXT_W-1:0] RST_EXTENT       = 23'd256;
  localparam logic [EXT_W-1:0] RST_PRISM_HEIGHT = 23'd512;
  localparam logic [CNT_W-1:0] RST_VERTEX_COUNT = 7'd0;

  // Vertex stream control from the table read into the edge unit.
  typedef struct packed {
    logic valid;
    logic first;
  } vtx_ctl_t;

  // Edge unit status back to the sequencer.
  typedef struct packed {
    logic busy;
    logic parity;
  } edge_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_t;

endpackage

@@ rtl/core/svct_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module svct_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/svct_edge.sv @@
// Pipelined even-odd edge crossing unit: one polygon edge per cycle.
module svct_edge (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clear,
  input  svct_pkg::vtx_ctl_t     vtx,
  input  logic signed [23:0]     vx,
  input  logic signed [23:0]     vy,
  input  logic signed [23:0]     px,
  input  logic signed [23:0]     py,
  output svct_pkg::edge_stat_t   stat
);

  logic signed [23:0] prev_x_r, prev_y_r;

  logic signed [24:0] ax_e, ay_e, bx_e, by_e, px_e, py_e;
  logic signed [24:0] d_nxt;
  logic               cross_nxt;

  logic               s1_vld_r, s1_cross_r, s1_dpos_r;
  logic signed [24:0] s1_d_r, s1_pxa_r, s1_bxa_r, s1_pya_r;

  logic               s2_vld_r, s2_cross_r, s2_dpos_r;
  logic signed [49:0] s2_lhs_r, s2_rhs_r;
  logic signed [49:0] lhs_nxt, rhs_nxt;

  logic               parity_r;
  logic               left;

  // The current vertex is the edge start a, the previous one is its end b.
  assign ax_e = {vx[23], vx};
  assign ay_e = {vy[23], vy};
  assign bx_e = {prev_x_r[23], prev_x_r};
  assign by_e = {prev_y_r[23], prev_y_r};
  assign px_e = {px[23], px};
  assign py_e = {py[23], py};

  assign d_nxt     = by_e - ay_e;
  assign cross_nxt = (vy > py) != (prev_y_r > py);

  assign lhs_nxt = s1_pxa_r * s1_d_r;
  assign rhs_nxt = s1_bxa_r * s1_pya_r;

  // The sign of the edge's y span decides which way the cross-multiplied compare points.
  assign left = s2_dpos_r ? (s2_lhs_r < s2_rhs_r) : (s2_lhs_r > s2_rhs_r);

  always_ff @(posedge clk) begin
    if (vtx.valid) begin
      prev_x_r <= vx;
      prev_y_r <= vy;
    end
    s1_cross_r <= cross_nxt;
    s1_dpos_r  <= d_nxt > 25'sd0;
    s1_d_r     <= d_nxt;
    s1_pxa_r   <= px_e - ax_e;
    s1_bxa_r   <= bx_e - ax_e;
    s1_pya_r   <= py_e - ay_e;
    s2_cross_r <= s1_cross_r;
    s2_dpos_r  <= s1_dpos_r;
    s2_lhs_r   <= lhs_nxt;
    s2_rhs_r   <= rhs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      s1_vld_r <= vtx.valid & ~vtx.first;
      s2_vld_r <= s1_vld_r;
      if (clear) begin
        parity_r <= 1'b0;
      end else if (s2_vld_r && s2_cross_r && left) begin
        parity_r <= ~parity_r;
      end
    end
  end

  assign stat.busy   = s1_vld_r | s2_vld_r;
  assign stat.parity = parity_r;

endmodule

@@ rtl/core/shape_volume_containment_test_top.sv @@
// Top level of the shape volume containment test: config port, vertex table and query sequencer.
//
// Each request is either a vertex write or a containment query. A vertex write produces no
// response. A box query is decided in the evaluation state, a sphere query in the sum state
// that follows it. A polygon prism query that passes the height and vertex-count checks
// walks the n vertices in use and then drains the edge pipeline; the vertex table has a
// single read port, so the walk fetches one vertex, hence one edge, per cycle. A prism
// query rejected by those checks is decided in the evaluation state. One query is in flight
// at a time, and the next request is taken once the current result is in the output register.
// The vertex table is not cleared at reset: entries must be written before a query uses them.
module shape_volume_containment_test_top #(
  parameter int MAX_VERTICES = svct_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // vertex_index[5:0], coord_x[29:6], coord_y[53:30],
                                  // coord_z[77:54], zero[79:78]
  input  logic [0:0]  in_tuser,   // opcode[0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // inside_res[0], zero[7:1]
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int TW = 2 * svct_pkg::CRD_W;

  // Configuration registers.
  logic [1:0]  mode_r;
  logic [22:0] hx_r, hy_r, hz_r, rad_r, hgt_r;
  logic [6:0]  vcnt_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // Input fields.
  logic               in_op;
  logic [5:0]         in_idx;
  logic signed [23:0] in_x, in_y, in_z;
  logic               in_acc;
  logic               slot_ok;
  logic               wr_en;

  // Query point.
  logic signed [23:0] px_r, py_r, pz_r;

  // Sequencer.
  svct_pkg::state_t   state_r, state_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [NW-1:0]      n_sat, n_m1;
  logic               ram_re, rd_first;
  logic [AW-1:0]      ram_raddr;
  logic [TW-1:0]      ram_rdata;
  svct_pkg::vtx_ctl_t rd_ctl_r;
  svct_pkg::edge_stat_t edge_stat;
  logic               edge_clr;
  logic               res_load, res_val, res_r;
  logic               out_load;
  logic               out_valid_r, out_res_r;

  // Shape evaluation.
  logic [23:0]        ax, ay, az;
  logic               box_in, z_over, n_small, walk_last, drain_done;
  logic signed [47:0] sqx_full, sqy_full, sqz_full;
  logic [45:0]        rr_full;
  logic [46:0]        sqx_r, sqy_r, sqz_r;
  logic [45:0]        rr_r;
  logic               sph_in;

  function automatic logic [23:0] abs24(input logic signed [23:0] v);
    abs24 = v[23] ? 24'(-v) : 24'(v);
  endfunction

  // ---------------------------------------------------------------- configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= svct_pkg::RST_SHAPE_MODE;
      hx_r   <= svct_pkg::RST_EXTENT;
      hy_r   <= svct_pkg::RST_EXTENT;
      hz_r   <= svct_pkg::RST_EXTENT;
      rad_r  <= svct_pkg::RST_EXTENT;
      hgt_r  <= svct_pkg::RST_PRISM_HEIGHT;
      vcnt_r <= svct_pkg::RST_VERTEX_COUNT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        svct_pkg::REG_SHAPE_MODE:    mode_r <= cfg_pwdata[1:0];
        svct_pkg::REG_BOX_HALF_X:    hx_r   <= cfg_pwdata[22:0];
        svct_pkg::REG_BOX_HALF_Y:    hy_r   <= cfg_pwdata[22:0];
        svct_pkg::REG_BOX_HALF_Z:    hz_r   <= cfg_pwdata[22:0];
        svct_pkg::REG_SPHERE_RADIUS: rad_r  <= cfg_pwdata[22:0];
        svct_pkg::REG_PRISM_HEIGHT:  hgt_r  <= cfg_pwdata[22:0];
        svct_pkg::REG_VERTEX_COUNT:  vcnt_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      svct_pkg::REG_SHAPE_MODE:    cfg_prdata = 32'(mode_r);
      svct_pkg::REG_BOX_HALF_X:    cfg_prdata = 32'(hx_r);
      svct_pkg::REG_BOX_HALF_Y:    cfg_prdata = 32'(hy_r);
      svct_pkg::REG_BOX_HALF_Z:    cfg_prdata = 32'(hz_r);
      svct_pkg::REG_SPHERE_RADIUS: cfg_prdata = 32'(rad_r);
      svct_pkg::REG_PRISM_HEIGHT:  cfg_prdata = 32'(hgt_r);
      svct_pkg::REG_VERTEX_COUNT:  cfg_prdata = 32'(vcnt_r);
      default:                     cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- input side
  assign in_op   = in_tuser[0];
  assign in_idx  = in_tdata[5:0];
  assign in_x    = in_tdata[29:6];
  assign in_y    = in_tdata[53:30];
  assign in_z    = in_tdata[77:54];

  assign in_tready = (state_r == svct_pkg::ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign slot_ok   = 32'(in_idx) < MAX_VERTICES;
  assign wr_en     = in_acc & (in_op == svct_pkg::OP_WRITE) & slot_ok;

  always_ff @(posedge clk) begin
    if (in_acc && (in_op == svct_pkg::OP_QUERY)) begin
      px_r <= in_x;
      py_r <= in_y;
      pz_r <= in_z;
    end
  end

  svct_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_idx)),
    .wdata ({in_y, in_x}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- shape checks
  assign ax     = abs24(px_r);
  assign ay     = abs24(py_r);
  assign az     = abs24(pz_r);
  assign box_in = (ax <= 24'(hx_r)) && (ay <= 24'(hy_r)) && (az <= 24'(hz_r));
  assign z_over = {az, 1'b0} > 25'(hgt_r);

  // Counts beyond the table depth saturate to the table depth.
  assign n_sat   = (32'(vcnt_r) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcnt_r);
  assign n_m1    = n_sat - NW'(1);
  assign n_small = 32'(n_sat) < 3;

  assign sqx_full = px_r * px_r;
  assign sqy_full = py_r * py_r;
  assign sqz_full = pz_r * pz_r;
  assign rr_full  = rad_r * rad_r;

  always_ff @(posedge clk) begin
    sqx_r <= sqx_full[46:0];
    sqy_r <= sqy_full[46:0];
    sqz_r <= sqz_full[46:0];
    rr_r  <= rr_full;
  end

  assign sph_in = (49'(sqx_r) + 49'(sqy_r) + 49'(sqz_r)) <= 49'(rr_r);

  // ---------------------------------------------------------------- edge walk
  svct_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (edge_clr),
    .vtx   (rd_ctl_r),
    .vx    (ram_rdata[23:0]),
    .vy    (ram_rdata[47:24]),
    .px    (px_r),
    .py    (py_r),
    .stat  (edge_stat)
  );

  assign walk_last  = (addr_r == n_m1[AW-1:0]);
  assign drain_done = !rd_ctl_r.valid && !edge_stat.busy;
  assign out_load   = (state_r == svct_pkg::ST_RESULT) && (!out_valid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svct_pkg::ST_IDLE: begin
        if (in_acc && (in_op == svct_pkg::OP_QUERY)) begin
          state_nxt = svct_pkg::ST_EVAL;
        end
      end
      svct_pkg::ST_EVAL: begin
        case (mode_r)
          svct_pkg::MODE_SPHERE: state_nxt = svct_pkg::ST_SUM;
          svct_pkg::MODE_PRISM: begin
            state_nxt = (z_over || n_small) ? svct_pkg::ST_RESULT : svct_pkg::ST_WALK;
          end
          default: state_nxt = svct_pkg::ST_RESULT;
        endcase
      end
      svct_pkg::ST_SUM:   state_nxt = svct_pkg::ST_RESULT;
      svct_pkg::ST_WALK: begin
        if (walk_last) begin
          state_nxt = svct_pkg::ST_DRAIN;
        end
      end
      svct_pkg::ST_DRAIN: begin
        if (drain_done) begin
          state_nxt = svct_pkg::ST_RESULT;
        end
      end
      svct_pkg::ST_RESULT: begin
        if (out_load) begin
          state_nxt = svct_pkg::ST_IDLE;
        end
      end
      default: state_nxt = svct_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. The walk reads the last vertex first so that the
  // closing edge is formed with vertex 0, then reads vertices 0 to n-1.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = addr_r;
    rd_first  = 1'b0;
    addr_nxt  = addr_r;
    edge_clr  = 1'b0;
    res_load  = 1'b0;
    res_val   = 1'b0;
    case (state_r)
      svct_pkg::ST_EVAL: begin
        edge_clr = 1'b1;
        case (mode_r)
          svct_pkg::MODE_BOX: begin
            res_load = 1'b1;
            res_val  = box_in;
          end
          svct_pkg::MODE_SPHERE: ;
          svct_pkg::MODE_PRISM: begin
            if (z_over || n_small) begin
              res_load = 1'b1;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = n_m1[AW-1:0];
              rd_first  = 1'b1;
              addr_nxt  = '0;
            end
          end
          default: res_load = 1'b1;
        endcase
      end
      svct_pkg::ST_SUM: begin
        res_load = 1'b1;
        res_val  = sph_in;
      end
      svct_pkg::ST_WALK: begin
        ram_re   = 1'b1;
        addr_nxt = addr_r + AW'(1);
      end
      svct_pkg::ST_DRAIN: begin
        res_load = drain_done;
        res_val  = edge_stat.parity;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svct_pkg::ST_IDLE;
      addr_r      <= '0;
      rd_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      addr_r         <= addr_nxt;
      rd_ctl_r.valid <= ram_re;
      rd_ctl_r.first <= rd_first;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_val;
    end
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r};

endmodule

@@ rtl/core/svct_checker.sv @@
// Port-level checker for the shape volume containment test, bound to the top level.
module svct_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [0:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A pending response holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("response dropped or changed while stalled");

  // Only the flag bit of the response carries data.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0)
    else $error("response padding not zero");

  // A query keeps the block busy for at least the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == svct_pkg::OP_QUERY) |=> !in_tready)
    else $error("request taken right after a query");

  // A vertex write never produces a response.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == svct_pkg::OP_WRITE) |=> !$rose(out_tvalid))
    else $error("response raised after a vertex write");

endmodule

bind shape_volume_containment_test_top svct_checker u_svct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
